/* rtl/core/cpss_pkg.sv */
// ----------------------------------------------------------------------------
// cpss_pkg
// Types, codes and limits shared by the charge phase and safety supervisor.
// ----------------------------------------------------------------------------
`default_nettype none

package cpss_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [16:0] OV_MARGIN_MV  = 17'd100;
  localparam logic [16:0] OC_MARGIN_MA  = 17'd100;
  localparam logic [12:0] OT_MARGIN_DC  = 13'd50;
  localparam logic [15:0] DROP_LIMIT_MV = 16'd500;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_ENABLE  = 2'd1,
    OP_DISABLE = 2'd2,
    OP_CLR_CNT = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_OFF     = 3'd0,
    PH_TRICKLE = 3'd1,
    PH_CC      = 3'd2,
    PH_CV      = 3'd3,
    PH_FULL    = 3'd4,
    PH_ERROR   = 3'd5,
    PH_TIMEOUT = 3'd6,
    PH_THERMAL = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    SF_OK       = 3'd0,
    SF_OVERVOLT = 3'd1,
    SF_OVERCURR = 3'd2,
    SF_OVERTEMP = 3'd3,
    SF_TIMEOUT  = 3'd4,
    SF_BATTERY  = 3'd5
  } safety_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_VOLTAGE = 4'd0,
    REG_MAX_CURRENT = 4'd1,
    REG_TRICKLE_V   = 4'd2,
    REG_CV_V        = 4'd3,
    REG_FULL_I      = 4'd4,
    REG_TIMEOUT     = 4'd5,
    REG_TEMP_MAX    = 4'd6,
    REG_TEMP_MIN    = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic        [15:0] max_voltage_mv;
    logic        [14:0] max_current_ma;
    logic        [15:0] trickle_voltage_mv;
    logic        [15:0] cv_voltage_mv;
    logic        [14:0] full_current_ma;
    logic        [31:0] session_limit_ms;
    logic signed [11:0] temp_max_dc;
    logic signed [11:0] temp_min_dc;
  } cfg_t;

  typedef struct packed {
    logic        [1:0]  op;
    logic        [15:0] battery_mv;
    logic signed [15:0] charge_ma;
    logic signed [11:0] temp_dc;
    logic               usb_present;
    logic        [31:0] now_ms;
    logic               safety_due;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  charge_state;
    logic [2:0]  safety_code;
    logic        enabled_out;
    logic [31:0] elapsed_ms;
    logic [31:0] cycle_count;
    logic        session_ended;
    logic        fault_event;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/core/cpss_if.sv */
// ----------------------------------------------------------------------------
// cpss channel interfaces
// Valid/ready channels for measurement items, result items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpss_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  op;
  logic        [15:0] battery_mv;
  logic signed [15:0] charge_ma;
  logic signed [11:0] temp_dc;
  logic               usb_present;
  logic        [31:0] now_ms;
  logic               safety_due;

  modport source (output valid, op, battery_mv, charge_ma, temp_dc, usb_present, now_ms,
                  safety_due, input ready);
  modport sink (input valid, op, battery_mv, charge_ma, temp_dc, usb_present, now_ms,
                safety_due, output ready);
endinterface

interface cpss_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  charge_state;
  logic [2:0]  safety_code;
  logic        enabled_out;
  logic [31:0] elapsed_ms;
  logic [31:0] cycle_count;
  logic        session_ended;
  logic        fault_event;

  modport source (output valid, charge_state, safety_code, enabled_out, elapsed_ms,
                  cycle_count, session_ended, fault_event, input ready);
  modport sink (input valid, charge_state, safety_code, enabled_out, elapsed_ms,
                cycle_count, session_ended, fault_event, output ready);
endinterface

interface cpss_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [cpss_pkg::CFG_IDX_W-1:0]      index;
  logic [cpss_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/cpss_cfg_regs.sv */
// ----------------------------------------------------------------------------
// cpss_cfg_regs
// Limit and threshold registers, written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module cpss_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            wr_en,
  input  wire logic [cpss_pkg::CFG_IDX_W-1:0]  wr_idx,
  input  wire logic [cpss_pkg::CFG_DATA_W-1:0] wr_data,
  output cpss_pkg::cfg_t                       cfg
);

  cpss_pkg::cfg_t cfg_r;
  cpss_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cpss_pkg::reg_idx_t'(wr_idx))
        cpss_pkg::REG_MAX_VOLTAGE: cfg_nxt.max_voltage_mv     = wr_data[15:0];
        cpss_pkg::REG_MAX_CURRENT: cfg_nxt.max_current_ma     = wr_data[14:0];
        cpss_pkg::REG_TRICKLE_V:   cfg_nxt.trickle_voltage_mv = wr_data[15:0];
        cpss_pkg::REG_CV_V:        cfg_nxt.cv_voltage_mv      = wr_data[15:0];
        cpss_pkg::REG_FULL_I:      cfg_nxt.full_current_ma    = wr_data[14:0];
        cpss_pkg::REG_TIMEOUT:     cfg_nxt.session_limit_ms   = wr_data[31:0];
        cpss_pkg::REG_TEMP_MAX:    cfg_nxt.temp_max_dc        = signed'(wr_data[11:0]);
        cpss_pkg::REG_TEMP_MIN:    cfg_nxt.temp_min_dc        = signed'(wr_data[11:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_voltage_mv     <= 16'd4200;
      cfg_r.max_current_ma     <= 15'd500;
      cfg_r.trickle_voltage_mv <= 16'd3000;
      cfg_r.cv_voltage_mv      <= 16'd4100;
      cfg_r.full_current_ma    <= 15'd50;
      cfg_r.session_limit_ms   <= 32'd14400000;
      cfg_r.temp_max_dc        <= 12'sd450;
      cfg_r.temp_min_dc        <= 12'sd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* rtl/core/cpss_step.sv */
// ----------------------------------------------------------------------------
// cpss_step
// Phase classification, session timing, safety check and supervisor state.
// ----------------------------------------------------------------------------
`default_nettype none

module cpss_step (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cpss_pkg::cfg_t     cfg,
  input  wire logic          fire,
  input  wire cpss_pkg::in_item_t item,
  output cpss_pkg::out_item_t res
);

  cpss_pkg::phase_t  phase_r,  phase_nxt;
  cpss_pkg::safety_t safety_r, safety_nxt;
  logic              enable_r, enable_nxt;
  logic [31:0]       start_r,  start_nxt;
  logic [31:0]       elapsed_r, elapsed_nxt;
  logic [15:0]       prior_r,  prior_nxt;
  logic [31:0]       cycles_r, cycles_nxt;

  cpss_pkg::phase_t  next_ph;
  cpss_pkg::safety_t chk;
  logic              ended;
  logic              fault;
  logic              therm;
  logic              timed_out;
  logic              timed_out_new;
  logic [31:0]       start_tick;
  logic [31:0]       elapsed_tick;
  logic [16:0]       ov_lim;
  logic signed [16:0] oc_lim;
  logic signed [12:0] ot_lim;
  logic [15:0]       drop;

  assign ov_lim = {1'b0, cfg.max_voltage_mv} + cpss_pkg::OV_MARGIN_MV;
  assign oc_lim = signed'({2'b00, cfg.max_current_ma} + cpss_pkg::OC_MARGIN_MA);
  assign ot_lim = 13'(signed'({cfg.temp_max_dc[11], cfg.temp_max_dc}))
                  + signed'(cpss_pkg::OT_MARGIN_DC);
  assign drop   = prior_r - item.battery_mv;
  assign therm  = (item.temp_dc > cfg.temp_max_dc) || (item.temp_dc < cfg.temp_min_dc);
  assign timed_out = elapsed_r > cfg.session_limit_ms;
  assign start_tick = ((phase_r == cpss_pkg::PH_OFF) && (next_ph != cpss_pkg::PH_OFF)) ?
                      item.now_ms : start_r;
  assign elapsed_tick = (next_ph != cpss_pkg::PH_OFF) ? item.now_ms - start_tick : 32'd0;
  assign timed_out_new = elapsed_tick > cfg.session_limit_ms;

  always_comb begin
    priority if (!enable_r || !item.usb_present) next_ph = cpss_pkg::PH_OFF;
    else if (safety_r != cpss_pkg::SF_OK)           next_ph = cpss_pkg::PH_ERROR;
    else if (timed_out)                             next_ph = cpss_pkg::PH_TIMEOUT;
    else if (therm)                                 next_ph = cpss_pkg::PH_THERMAL;
    else if (item.battery_mv < cfg.trickle_voltage_mv) next_ph = cpss_pkg::PH_TRICKLE;
    else if (item.battery_mv < cfg.cv_voltage_mv)   next_ph = cpss_pkg::PH_CC;
    else if (item.charge_ma > signed'({1'b0, cfg.full_current_ma}))
                                                    next_ph = cpss_pkg::PH_CV;
    else                                            next_ph = cpss_pkg::PH_FULL;
  end

  always_comb begin
    priority if ({1'b0, item.battery_mv} > ov_lim)           chk = cpss_pkg::SF_OVERVOLT;
    else if (17'(item.charge_ma) > oc_lim)                   chk = cpss_pkg::SF_OVERCURR;
    else if (13'(item.temp_dc) > ot_lim)                     chk = cpss_pkg::SF_OVERTEMP;
    else if (timed_out_new)                                  chk = cpss_pkg::SF_TIMEOUT;
    else if ((prior_r > item.battery_mv) && (drop > cpss_pkg::DROP_LIMIT_MV))
                                                             chk = cpss_pkg::SF_BATTERY;
    else                                                     chk = cpss_pkg::SF_OK;
  end

  always_comb begin
    phase_nxt   = phase_r;
    safety_nxt  = safety_r;
    enable_nxt  = enable_r;
    start_nxt   = start_r;
    elapsed_nxt = elapsed_r;
    prior_nxt   = prior_r;
    cycles_nxt  = cycles_r;
    ended       = 1'b0;
    fault       = 1'b0;
    unique case (cpss_pkg::op_t'(item.op))
      cpss_pkg::OP_TICK: begin
        if (next_ph != phase_r) begin
          if (phase_r == cpss_pkg::PH_OFF) begin
            start_nxt = item.now_ms;
          end else if (next_ph == cpss_pkg::PH_OFF) begin
            cycles_nxt = cycles_r + 32'd1;
            ended      = 1'b1;
          end
        end
        phase_nxt   = next_ph;
        elapsed_nxt = elapsed_tick;
        if (item.safety_due) begin
          safety_nxt = chk;
          if (chk == cpss_pkg::SF_OK) begin
            prior_nxt = item.battery_mv;
          end else begin
            fault = 1'b1;
            if (chk != cpss_pkg::SF_TIMEOUT) enable_nxt = 1'b0;
          end
        end
      end
      cpss_pkg::OP_ENABLE:  enable_nxt = 1'b1;
      cpss_pkg::OP_DISABLE: enable_nxt = 1'b0;
      cpss_pkg::OP_CLR_CNT: cycles_nxt = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= cpss_pkg::PH_OFF;
      safety_r  <= cpss_pkg::SF_OK;
      enable_r  <= 1'b1;
      start_r   <= 32'd0;
      elapsed_r <= 32'd0;
      prior_r   <= 16'd0;
      cycles_r  <= 32'd0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      safety_r  <= safety_nxt;
      enable_r  <= enable_nxt;
      start_r   <= start_nxt;
      elapsed_r <= elapsed_nxt;
      prior_r   <= prior_nxt;
      cycles_r  <= cycles_nxt;
    end
  end

  assign res.charge_state  = phase_nxt;
  assign res.safety_code   = safety_nxt;
  assign res.enabled_out   = enable_nxt;
  assign res.elapsed_ms    = elapsed_nxt;
  assign res.cycle_count   = cycles_nxt;
  assign res.session_ended = ended;
  assign res.fault_event   = fault;

endmodule

`default_nettype wire

/* rtl/core/charger_phase_safety_supervisor_unit.sv */
// ----------------------------------------------------------------------------
// charger_phase_safety_supervisor_unit
// CC/CV charge phase and safety supervisor: one result item per input item.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  in_if    in   valid/ready    op, battery_mv, charge_ma, temp_dc, usb_present,
//                               now_ms, safety_due
//  out_if   out  valid/ready    charge_state, safety_code, enabled_out, elapsed_ms,
//                               cycle_count, session_ended, fault_event
//  cfg_if   in   valid/ready    index, data (always ready)
//
//  One item per cycle sustained while the result channel is not stalled; items
//  pass through the input register and the result register, with the single
//  pass of classify and check logic between them. Synchronous reset restores
//  limits and supervisor state. A stalled result holds in the output register
//  while the input register still takes one more item.
// ----------------------------------------------------------------------------
`default_nettype none

module charger_phase_safety_supervisor_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cpss_in_if.sink    in_if,
  cpss_out_if.source out_if,
  cpss_cfg_if.sink   cfg_if
);

  cpss_pkg::cfg_t      cfg;
  cpss_pkg::in_item_t  in_r;
  cpss_pkg::out_item_t res;
  cpss_pkg::out_item_t out_r;
  logic                in_v_r;
  logic                out_v_r;
  logic                out_free;
  logic                fire;
  logic                take;

  assign cfg_if.ready = 1'b1;

  cpss_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_if.valid),
    .wr_idx  (cfg_if.index),
    .wr_data (cfg_if.data),
    .cfg     (cfg)
  );

  assign out_free    = !out_v_r || out_if.ready;
  assign fire        = in_v_r && out_free;
  assign in_if.ready = !in_v_r || out_free;
  assign take        = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_if.ready) begin
      in_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_r.op          <= in_if.op;
      in_r.battery_mv  <= in_if.battery_mv;
      in_r.charge_ma   <= in_if.charge_ma;
      in_r.temp_dc     <= in_if.temp_dc;
      in_r.usb_present <= in_if.usb_present;
      in_r.now_ms      <= in_if.now_ms;
      in_r.safety_due  <= in_if.safety_due;
    end
  end

  cpss_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (fire),
    .item  (in_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_if.valid         = out_v_r;
  assign out_if.charge_state  = out_r.charge_state;
  assign out_if.safety_code   = out_r.safety_code;
  assign out_if.enabled_out   = out_r.enabled_out;
  assign out_if.elapsed_ms    = out_r.elapsed_ms;
  assign out_if.cycle_count   = out_r.cycle_count;
  assign out_if.session_ended = out_r.session_ended;
  assign out_if.fault_event   = out_r.fault_event;

endmodule

`default_nettype wire

/* tb/tb_charger_phase_safety_supervisor_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_charger_phase_safety_supervisor_unit
// Drives measurement and command items into the charge supervisor and
// tracks phase, safety latch, session timing and cycle count alongside it.
// Every result item is checked field by field, in order, under several limit
// settings and with random gaps on the input and back-pressure on the output.
// ----------------------------------------------------------------------------

module tb_charger_phase_safety_supervisor_unit;
  import cpss_pkg::*;

  class charge_status_board;
    logic        [15:0] max_v;
    logic        [14:0] max_i;
    logic        [15:0] trk_v;
    logic        [15:0] cv_v;
    logic        [14:0] full_i;
    logic        [31:0] tmo;
    logic signed [11:0] tmax;
    logic signed [11:0] tmin;
    phase_t             phase;
    safety_t            safety;
    bit                 en;
    logic        [31:0] start;
    logic        [31:0] elapsed;
    logic        [31:0] cycles;
    logic        [15:0] prior_v;
    out_item_t          status_q[$];
    int                 errors;
    int                 shown;

    function new();
      max_v   = 16'd4200;
      max_i   = 15'd500;
      trk_v   = 16'd3000;
      cv_v    = 16'd4100;
      full_i  = 15'd50;
      tmo     = 32'd14400000;
      tmax    = 12'sd450;
      tmin    = 12'sd0;
      phase   = PH_OFF;
      safety  = SF_OK;
      en      = 1'b1;
      start   = '0;
      elapsed = '0;
      cycles  = '0;
      prior_v = '0;
      errors  = 0;
      shown   = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] d);
      case (idx)
        REG_MAX_VOLTAGE: max_v  = d[15:0];
        REG_MAX_CURRENT: max_i  = d[14:0];
        REG_TRICKLE_V:   trk_v  = d[15:0];
        REG_CV_V:        cv_v   = d[15:0];
        REG_FULL_I:      full_i = d[14:0];
        REG_TIMEOUT:     tmo    = d;
        REG_TEMP_MAX:    tmax   = d[11:0];
        REG_TEMP_MIN:    tmin   = d[11:0];
        default: ;
      endcase
    endfunction

    function phase_t classify(in_item_t it);
      int ma;
      int t;
      ma = $signed(it.charge_ma);
      t  = $signed(it.temp_dc);
      if (!en || !it.usb_present) return PH_OFF;
      if (safety != SF_OK) return PH_ERROR;
      if (elapsed > tmo) return PH_TIMEOUT;
      if (t > int'(tmax) || t < int'(tmin)) return PH_THERMAL;
      if (it.battery_mv < trk_v) return PH_TRICKLE;
      if (it.battery_mv < cv_v) return PH_CC;
      if (ma > int'(full_i)) return PH_CV;
      return PH_FULL;
    endfunction

    function safety_t run_check(in_item_t it);
      int mv;
      int ma;
      int t;
      mv = it.battery_mv;
      ma = $signed(it.charge_ma);
      t  = $signed(it.temp_dc);
      if (mv > int'(max_v) + int'(OV_MARGIN_MV)) return SF_OVERVOLT;
      if (ma > int'(max_i) + int'(OC_MARGIN_MA)) return SF_OVERCURR;
      if (t > int'(tmax) + int'(OT_MARGIN_DC)) return SF_OVERTEMP;
      if (elapsed > tmo) return SF_TIMEOUT;
      if (prior_v != 0 && int'(prior_v) - mv > int'(DROP_LIMIT_MV)) return SF_BATTERY;
      prior_v = it.battery_mv;
      return SF_OK;
    endfunction

    function void note_item(in_item_t it);
      out_item_t exp_st;
      phase_t    nxt;
      bit        ended;
      bit        fault;
      ended = 1'b0;
      fault = 1'b0;
      case (op_t'(it.op))
        OP_TICK: begin
          nxt = classify(it);
          if (nxt != phase) begin
            if (phase == PH_OFF) begin
              start = it.now_ms;
            end else if (nxt == PH_OFF) begin
              cycles = cycles + 32'd1;
              ended  = 1'b1;
            end
            phase = nxt;
          end
          elapsed = (phase != PH_OFF) ? it.now_ms - start : 32'd0;
          if (it.safety_due) begin
            safety = run_check(it);
            if (safety != SF_OK) begin
              fault = 1'b1;
              if (safety != SF_TIMEOUT) en = 1'b0;
            end
          end
        end
        OP_ENABLE:  en = 1'b1;
        OP_DISABLE: en = 1'b0;
        default:    cycles = '0;
      endcase
      exp_st.charge_state  = phase;
      exp_st.safety_code   = safety;
      exp_st.enabled_out   = en;
      exp_st.elapsed_ms    = elapsed;
      exp_st.cycle_count   = cycles;
      exp_st.session_ended = ended;
      exp_st.fault_event   = fault;
      status_q.push_back(exp_st);
    endfunction

    function void cmp_field(string name, logic [31:0] e, logic [31:0] a);
      if (a !== e) begin
        errors++;
        if (shown < 100) begin
          shown++;
          $display("%0t: %s expected %0h actual %0h", $time, name, e, a);
        end
      end
    endfunction

    function void check_status(out_item_t got);
      out_item_t exp_st;
      if (status_q.size() == 0) begin
        errors++;
        if (shown < 100) begin
          shown++;
          $display("%0t: unexpected result item, expected none actual %p", $time, got);
        end
        return;
      end
      exp_st = status_q.pop_front();
      cmp_field("charge_state", exp_st.charge_state, got.charge_state);
      cmp_field("safety_code", exp_st.safety_code, got.safety_code);
      cmp_field("enabled_out", exp_st.enabled_out, got.enabled_out);
      cmp_field("elapsed_ms", exp_st.elapsed_ms, got.elapsed_ms);
      cmp_field("cycle_count", exp_st.cycle_count, got.cycle_count);
      cmp_field("session_ended", exp_st.session_ended, got.session_ended);
      cmp_field("fault_event", exp_st.fault_event, got.fault_event);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  cpss_in_if  in_if();
  cpss_out_if out_if();
  cpss_cfg_if cfg_if();

  charger_phase_safety_supervisor_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  charge_status_board sb;
  int                 tx_idle_pct = 11;
  int                 rx_idle_pct = 72;
  int                 hold_cycles = 0;
  logic [31:0]        clock_ms;
  int                 drift_mv;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (cfg_if.valid && cfg_if.ready) sb.set_reg(reg_idx_t'(cfg_if.index), cfg_if.data);
      if (in_if.valid && in_if.ready) begin
        sb.note_item(in_item_t'{in_if.op, in_if.battery_mv, in_if.charge_ma, in_if.temp_dc,
                                in_if.usb_present, in_if.now_ms, in_if.safety_due});
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_status(out_item_t'{out_if.charge_state, out_if.safety_code,
                                    out_if.enabled_out, out_if.elapsed_ms,
                                    out_if.cycle_count, out_if.session_ended,
                                    out_if.fault_event});
      end
    end
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_item(in_item_t it);
    in_if.valid       <= 1'b1;
    in_if.op          <= it.op;
    in_if.battery_mv  <= it.battery_mv;
    in_if.charge_ma   <= it.charge_ma;
    in_if.temp_dc     <= it.temp_dc;
    in_if.usb_present <= it.usb_present;
    in_if.now_ms      <= it.now_ms;
    in_if.safety_due  <= it.safety_due;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic tick(int mv, int ma, int t, bit usb, logic [31:0] now, bit due);
    in_item_t it;
    it.op          = OP_TICK;
    it.battery_mv  = mv[15:0];
    it.charge_ma   = ma[15:0];
    it.temp_dc     = t[11:0];
    it.usb_present = usb;
    it.now_ms      = now;
    it.safety_due  = due;
    send_item(it);
  endtask

  task automatic command(op_t op);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, 16'($urandom)});
    it.temp_dc = 12'(int'($urandom_range(0, 3000)) - 1000);
    it.op = op;
    send_item(it);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  task automatic apply_limits(logic [15:0] mv, logic [14:0] mi, logic [15:0] tv,
                              logic [15:0] cv, logic [14:0] fi, logic [31:0] to,
                              int tx, int tn);
    write_reg(REG_MAX_VOLTAGE, {16'h0, mv});
    write_reg(REG_MAX_CURRENT, {17'h0, mi});
    write_reg(REG_TRICKLE_V, {16'h0, tv});
    write_reg(REG_CV_V, {16'h0, cv});
    write_reg(REG_FULL_I, {17'h0, fi});
    write_reg(REG_TIMEOUT, to);
    write_reg(REG_TEMP_MAX, 32'(tx));
    write_reg(REG_TEMP_MIN, 32'(tn));
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.status_q.size() != 0) @(posedge clk);
  endtask

  function automatic in_item_t next_item();
    in_item_t it;
    int       r;
    int       lo;
    int       hi;
    int       ma;
    int       t;
    r  = $urandom_range(0, 99);
    it = in_item_t'({$urandom, $urandom, 16'($urandom)});
    it.temp_dc = 12'(int'($urandom_range(0, 3000)) - 1000);
    if (!sb.en && r < 30) begin
      it.op = OP_ENABLE;
      return it;
    end
    if (r < 2) begin
      it.op = OP_DISABLE;
      return it;
    end
    if (r < 4) begin
      it.op = OP_CLR_CNT;
      return it;
    end
    if (r < 6) begin
      it.op = OP_ENABLE;
      return it;
    end
    it.op = OP_TICK;
    if (r < 14) return it;

    if (r < 17) clock_ms = clock_ms + $urandom_range(1000, 100000);
    else clock_ms = clock_ms + $urandom_range(1, 500);

    lo = int'(sb.trk_v) - 300;
    hi = int'(sb.max_v) + 200;
    if (lo < 0) lo = 0;
    if (hi > 65535) hi = 65535;
    if (lo > hi) begin
      t  = lo;
      lo = hi;
      hi = t;
    end
    if (r < 20) drift_mv = drift_mv - int'($urandom_range(501, 900));
    else drift_mv = drift_mv + int'($urandom_range(0, 60)) - 20;
    if (r >= 96 || drift_mv < lo - 500 || drift_mv > hi + 500)
      drift_mv = lo + int'($urandom_range(0, hi - lo));
    if (drift_mv < 0) drift_mv = 0;
    if (drift_mv > 65535) drift_mv = 65535;

    if ($urandom_range(0, 1)) ma = int'(sb.full_i) + int'($urandom_range(0, 40)) - 20;
    else ma = int'($urandom_range(0, int'(sb.max_i) + 250)) - 100;
    if (ma > 32767) ma = 32767;

    lo = (sb.tmin < sb.tmax) ? int'(sb.tmin) : int'(sb.tmax);
    hi = (sb.tmin < sb.tmax) ? int'(sb.tmax) : int'(sb.tmin);
    lo = lo - 30;
    hi = hi + 80;
    if (lo < -1000) lo = -1000;
    if (hi > 2000) hi = 2000;
    t = lo + int'($urandom_range(0, hi - lo));

    it.battery_mv  = drift_mv[15:0];
    it.charge_ma   = ma[15:0];
    it.temp_dc     = t[11:0];
    it.usb_present = ($urandom_range(0, 99) < 95);
    it.now_ms      = clock_ms;
    it.safety_due  = ($urandom_range(0, 99) < 35);
    return it;
  endfunction

  task automatic run_items(int n);
    repeat (n) begin
      send_item(next_item());
      if ($urandom_range(0, 99) < tx_idle_pct) begin
        in_if.valid <= 1'b0;
        do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.op          <= OP_TICK;
    in_if.battery_mv  <= '0;
    in_if.charge_ma   <= '0;
    in_if.temp_dc     <= '0;
    in_if.usb_present <= 1'b0;
    in_if.now_ms      <= '0;
    in_if.safety_due  <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= REG_MAX_VOLTAGE;
    cfg_if.data       <= '0;
    clock_ms = 32'd20000;
    drift_mv = 2800;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tick(3500, 100, 250, 0, 100, 0);
    tick(2500, 100, 250, 1, 200, 1);
    tick(3500, 300, 250, 1, 300, 0);
    tick(4150, 200, 250, 1, 400, 0);
    tick(4150, 50, 250, 1, 500, 0);
    tick(4150, 50, 451, 1, 600, 0);
    tick(4150, 50, -1, 1, 700, 0);
    tick(4301, 100, 250, 1, 800, 1);
    tick(4000, 100, 250, 1, 900, 0);
    command(OP_ENABLE);
    tick(4000, 100, 250, 1, 1000, 1);
    tick(4000, 601, 250, 1, 1100, 1);
    command(OP_ENABLE);
    tick(4000, 100, 501, 1, 1200, 1);
    command(OP_ENABLE);
    tick(4000, 100, 250, 1, 1300, 1);
    tick(3499, 100, 250, 1, 1400, 1);
    command(OP_CLR_CNT);
    command(OP_ENABLE);
    tick(65535, -32768, -1000, 1, 32'hFFFF_FFFF, 1);
    command(OP_DISABLE);
    tick(0, 32767, 2000, 1, 0, 1);
    command(OP_ENABLE);
    tick(0, 0, 0, 1, 5, 1);
    drain();

    apply_limits(16'd4200, 15'd500, 16'd3000, 16'd4100, 15'd50, 32'd2000, 450, 0);
    command(OP_ENABLE);
    tick(3500, 100, 250, 1, 10000, 1);
    tick(3500, 100, 250, 1, 13000, 1);
    tick(3500, 100, 250, 1, 13100, 0);
    run_items(20);
    hold_cycles = 150;
    run_items(130);
    drain();

    apply_limits(16'hFFFF, 15'h7FFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 32'hFFFF_FFFF, 2000, -1000);
    run_items(125);
    drain();

    tx_idle_pct = 72;
    rx_idle_pct = 11;
    apply_limits(16'd0, 15'd0, 16'd0, 16'd0, 15'd0, 32'd0, -1000, -1000);
    run_items(125);
    drain();

    begin
      logic [15:0] tv;
      logic [15:0] cv;
      tv = 16'($urandom_range(2500, 3500));
      cv = 16'(tv + $urandom_range(0, 1200));
      apply_limits(16'(cv + $urandom_range(0, 300)), 15'($urandom_range(100, 2000)), tv, cv,
                   15'($urandom_range(0, 300)), $urandom_range(500, 20000),
                   int'($urandom_range(0, 3000)) - 1000, int'($urandom_range(0, 3000)) - 1000);
    end
    run_items(125);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apply_limits(16'($urandom), 15'($urandom), 16'($urandom), 16'($urandom), 15'($urandom),
                 $urandom,
                 int'($urandom_range(0, 3000)) - 1000, int'($urandom_range(0, 3000)) - 1000);
    run_items(125);
    drain();

    apply_limits(16'd4200, 15'd500, 16'd3000, 16'd4100, 15'd50, 32'd5000, 450, 0);
    clock_ms = 32'hFFFF_F000;
    drift_mv = 2900;
    run_items(125);
    drain();

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.status_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
